/* rtl/core/scan_object_segmenter_defines.svh */
// Assertion macros for the scan object segmenter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SCAN_OBJECT_SEGMENTER_DEFINES_SVH
`define SCAN_OBJECT_SEGMENTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while the asynchronous active-low reset is asserted.
`define SOS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sos check failed");
// Clocked check that also holds through reset.
`define SOS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sos check failed");
`else
`define SOS_ASSERT(label, clk, rst_n, prop)
`define SOS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/core/sos_pkg.sv */
// Shared types and constants for the scan object segmenter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sos_pkg;

  // Field widths
  localparam int unsigned NEAR_W   = 12;
  localparam int unsigned RANGE_W  = 14;
  localparam int unsigned OBJ_W    = 4;
  localparam int unsigned DPS_W    = 8;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned WIDTH_W  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_THRESHOLD = 2'd0,
    CFG_MAX_OBJECTS    = 2'd1,
    CFG_DEG_PER_STEP   = 2'd2
  } cfg_reg_e;

  // Register reset values
  localparam logic [NEAR_W-1:0] NEAR_THR_RST = 12'd1000;
  localparam logic [OBJ_W-1:0]  MAX_OBJ_RST  = 4'd7;
  localparam logic [DPS_W-1:0]  DPS_RST      = 8'd2;

  localparam logic [OBJ_W-1:0] OBJ_COUNT_MAX = 4'd15;

  // pi/180 in unsigned Q0.24
  localparam int unsigned K_W            = 19;
  localparam logic [K_W-1:0] DEG_TO_RAD_Q24 = 19'd292818;
  localparam int unsigned FRAC_BITS      = 24;

  localparam int unsigned ANGLE_LIMIT = 360;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 16'hFFFF;

  localparam int unsigned MAX_SAMPLES_DEF = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_ANGLE,
    ST_MUL_SPAN,
    ST_MUL_AREA,
    ST_MUL_SCALE,
    ST_ROUND,
    ST_DONE
  } seg_state_e;

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MUL_IDLE,
    MUL_ANGLE,
    MUL_SPAN,
    MUL_RANGE_SPAN,
    MUL_SCALE
  } mul_op_e;

endpackage

`default_nettype wire

/* rtl/core/scan_object_segmenter.sv */
// Scan object segmenter top level: sequencer, sweep state and result register.
// Depends on sos_pkg, sos_range_mem, sos_mul_unit and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "scan_object_segmenter_defines.svh"

// Finds objects in an angular sweep, one sample word per input handshake. A
// sample counts as near when its reading is at or above near_threshold; a run
// opens at a sample when it and the next are both near (while fewer than
// max_objects runs have closed this sweep) and closes when a sample and the
// next are both far, or on the sample flagged final_sample. Each sample is
// therefore decided when its successor arrives, and exactly one result word
// leaves per sample word; object_found marks the ones that report a closed
// run, sweep_done the one for the final sample. Ranges are kept in a
// MAX_SAMPLES-deep line so the middle and start ranges can be fetched on
// closing; indices saturate at MAX_SAMPLES-1 on overlong sweeps.
// Sequencing: a sample that closes no run goes from the decision state to the
// done state, where its result is loaded into the output register; one that
// closes a run first makes four passes through the single shared multiplier
// (angle, span in degrees, start range times span, times pi/180 in Q0.24)
// interleaved with two range line reads, then a rounding step. No new sample
// is taken before the result of the last one has been loaded.
// Input stall is high from acceptance until the result is loaded into the
// output register; a further sample is taken while that result waits.
// Configuration writes are taken at any time but are meant for idle periods.
// No clearing pass after reset: range entries are always written before read.

module scan_object_segmenter
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // sample words in
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [NEAR_W-1:0]     near_reading_i,
  input  wire logic [RANGE_W-1:0]    range_value_i,
  input  wire logic                  final_sample_i,
  // result words out
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       object_found_o,
  output logic [OBJ_W-1:0]           object_number_o,
  output logic [ANGLE_W-1:0]         center_angle_o,
  output logic [WIDTH_W-1:0]         object_width_o,
  output logic [RANGE_W-1:0]         center_range_o,
  output logic                       sweep_done_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned P_W   = RANGE_W + DPS_W + IDX_W + K_W;
  localparam int unsigned SH_W  = P_W + 1 - FRAC_BITS;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);
  localparam logic [P_W:0] ROUND_BIAS = (P_W + 1)'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------- config
  logic [NEAR_W-1:0] near_thr_q;
  logic [OBJ_W-1:0]  max_obj_q;
  logic [DPS_W-1:0]  dps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q <= NEAR_THR_RST;
      max_obj_q  <= MAX_OBJ_RST;
      dps_q      <= DPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NEAR_THRESHOLD: near_thr_q <= cfg_wdata_i[NEAR_W-1:0];
        CFG_MAX_OBJECTS:    max_obj_q  <= cfg_wdata_i[OBJ_W-1:0];
        CFG_DEG_PER_STEP:   dps_q      <= cfg_wdata_i[DPS_W-1:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  seg_state_e state_q, state_d;
  mul_op_e    mul_op;
  logic       accept;
  logic       load_out;
  logic       mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic       close_d;

  // captured sample
  logic [NEAR_W-1:0]  item_near_q;
  logic [RANGE_W-1:0] item_range_q;
  logic               item_fin_q;

  // sweep state
  logic [NEAR_W-1:0] pend_near_q;
  logic              pend_valid_q;
  logic [IDX_W-1:0]  sample_cnt_q;
  logic              run_open_q;
  logic [IDX_W-1:0]  run_start_q;
  logic [OBJ_W-1:0]  obj_seen_q;

  // closing run under evaluation
  logic              close_q;
  logic [IDX_W-1:0]  start_q;
  logic [IDX_W-1:0]  mid_q;
  logic [IDX_W-1:0]  span_q;
  logic [OBJ_W-1:0]  num_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [RANGE_W-1:0] start_rng_q;
  logic [RANGE_W-1:0] mid_rng_q;
  logic [WIDTH_W-1:0] width_q;

  // output register
  logic               out_valid_q;
  logic               found_q;
  logic [OBJ_W-1:0]   out_num_q;
  logic [ANGLE_W-1:0] out_angle_q;
  logic [WIDTH_W-1:0] out_width_q;
  logic [RANGE_W-1:0] out_range_q;
  logic               out_done_q;

  logic [RANGE_W-1:0] mem_rdata;
  logic [P_W-1:0]     product;

  assign accept   = in_valid_i && !in_stall_o;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_DECIDE;
      ST_DECIDE:    state_d = close_d ? ST_MUL_ANGLE : ST_DONE;
      ST_MUL_ANGLE: state_d = ST_MUL_SPAN;
      ST_MUL_SPAN:  state_d = ST_MUL_AREA;
      ST_MUL_AREA:  state_d = ST_MUL_SCALE;
      ST_MUL_SCALE: state_d = ST_ROUND;
      ST_ROUND:     state_d = ST_DONE;
      ST_DONE:      if (load_out) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mul_op     = MUL_IDLE;
    mem_re     = 1'b0;
    mem_raddr  = start_q;
    unique case (state_q)
      ST_IDLE:      in_stall_o = 1'b0;
      ST_MUL_ANGLE: begin
        mul_op = MUL_ANGLE;
        mem_re = 1'b1;
      end
      ST_MUL_SPAN: begin
        mul_op    = MUL_SPAN;
        mem_re    = 1'b1;
        mem_raddr = mid_q;
      end
      ST_MUL_AREA:  mul_op = MUL_RANGE_SPAN;
      ST_MUL_SCALE: mul_op = MUL_SCALE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_near_q  <= near_reading_i;
      item_range_q <= range_value_i;
      item_fin_q   <= final_sample_i;
    end
  end

  // ---------------------------------------------------------------- decision
  // Previous sample gets decided now; final sample also closes any open run.
  logic             dec_en;
  logic [IDX_W-1:0] prev_idx;
  logic             prev_near;
  logic             cur_near;
  logic             open_now;
  logic             close_prev;
  logic             open_after;
  logic [IDX_W-1:0] start_after;
  logic [IDX_W-1:0] end_idx;
  logic [IDX_W-1:0] span_d;

  assign dec_en     = (state_q == ST_DECIDE);
  assign prev_idx   = (sample_cnt_q != '0) ? sample_cnt_q - 1'b1 : '0;
  assign prev_near  = pend_near_q >= near_thr_q;
  assign cur_near   = item_near_q >= near_thr_q;
  assign open_now   = pend_valid_q && !run_open_q && prev_near && cur_near
                      && (obj_seen_q < max_obj_q);
  assign close_prev = pend_valid_q && run_open_q && !prev_near && !cur_near;
  assign open_after = open_now || (run_open_q && !close_prev);
  assign start_after = open_now ? prev_idx : run_start_q;
  assign close_d    = close_prev || (item_fin_q && open_after);
  assign end_idx    = close_prev ? prev_idx : sample_cnt_q;
  assign span_d     = (end_idx >= start_after) ? end_idx - start_after : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_near_q  <= '0;
      pend_valid_q <= 1'b0;
      sample_cnt_q <= '0;
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      obj_seen_q   <= '0;
      close_q      <= 1'b0;
    end else if (dec_en) begin
      close_q <= close_d;
      if (item_fin_q) begin
        pend_near_q  <= '0;
        pend_valid_q <= 1'b0;
        sample_cnt_q <= '0;
        run_open_q   <= 1'b0;
        run_start_q  <= '0;
        obj_seen_q   <= '0;
      end else begin
        pend_near_q  <= item_near_q;
        pend_valid_q <= 1'b1;
        if (sample_cnt_q != IDX_LAST) begin
          sample_cnt_q <= sample_cnt_q + 1'b1;
        end
        run_open_q  <= open_after && !close_d;
        run_start_q <= start_after;
        if (close_d && obj_seen_q != OBJ_COUNT_MAX) begin
          obj_seen_q <= obj_seen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_en) begin
      start_q <= start_after;
      span_q  <= span_d;
      mid_q   <= start_after + (span_d >> 1);
      num_q   <= obj_seen_q;
    end
  end

  // ---------------------------------------------------------------- datapath
  sos_range_mem #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_range_mem (
    .clk_i   (clk_i),
    .we_i    (dec_en),
    .waddr_i (sample_cnt_q),
    .wdata_i (item_range_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sos_mul_unit #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_mul (
    .clk_i     (clk_i),
    .op_i      (mul_op),
    .mid_i     (mid_q),
    .span_i    (span_q),
    .dps_i     (dps_q),
    .range_i   (start_rng_q),
    .product_o (product)
  );

  // round half up from Q.24, then saturate
  logic [P_W:0]       round_sum;
  logic [SH_W-1:0]    round_sh;
  logic [WIDTH_W-1:0] width_d;
  logic [ANGLE_W-1:0] angle_d;

  assign round_sum = {1'b0, product} + ROUND_BIAS;
  assign round_sh  = round_sum[P_W:FRAC_BITS];
  assign width_d   = (round_sh > SH_W'(WIDTH_LIMIT)) ? WIDTH_LIMIT : round_sh[WIDTH_W-1:0];
  assign angle_d   = (product > P_W'(ANGLE_LIMIT)) ? ANGLE_W'(ANGLE_LIMIT)
                                                   : product[ANGLE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL_SPAN) begin
      angle_q     <= angle_d;     // dps * mid
      start_rng_q <= mem_rdata;   // range at run start
    end
    if (state_q == ST_MUL_AREA) begin
      mid_rng_q <= mem_rdata;
    end
    if (state_q == ST_ROUND) begin
      width_q <= width_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_q     <= close_q;
      out_num_q   <= close_q ? num_q : '0;
      out_angle_q <= close_q ? angle_q : '0;
      out_width_q <= close_q ? width_q : '0;
      out_range_q <= close_q ? mid_rng_q : '0;
      out_done_q  <= item_fin_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign object_found_o  = found_q;
  assign object_number_o = out_num_q;
  assign center_angle_o  = out_angle_q;
  assign object_width_o  = out_width_q;
  assign center_range_o  = out_range_q;
  assign sweep_done_o    = out_done_q;

  // ---------------------------------------------------------------- checks
  `SOS_ASSERT(a_empty_result_zero, clk_i, rst_ni,
    (out_valid_o && !object_found_o) |-> (object_number_o == '0 && center_angle_o == '0
      && object_width_o == '0 && center_range_o == '0))
  `SOS_ASSERT(a_angle_limit, clk_i, rst_ni,
    out_valid_o |-> (center_angle_o <= ANGLE_W'(ANGLE_LIMIT)))
  `SOS_ASSERT(a_sweep_end_clears, clk_i, rst_ni,
    (dec_en && item_fin_q) |=> (!pend_valid_q && !run_open_q && sample_cnt_q == '0))
  `SOS_ASSERT_ALWAYS(a_run_within_sweep, clk_i,
    run_open_q |-> pend_valid_q)
  `SOS_ASSERT(a_stall_until_result, clk_i, rst_ni,
    (state_q != ST_IDLE) |-> in_stall_o)

endmodule

`default_nettype wire

/* rtl/core/sos_range_mem.sv */
// Range line store: one range word per sample index, registered read.
// Depends on sos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sos_range_mem
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]   waddr_i,
  input  wire logic [RANGE_W-1:0]               wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]   raddr_i,
  output logic      [RANGE_W-1:0]               rdata_o
);

  logic [RANGE_W-1:0] mem_q [MAX_SAMPLES];
  logic [RANGE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/sos_mul_unit.sv */
// Shared multiplier with its own operand select and registered product.
// Depends on sos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sos_mul_unit
  import sos_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                                         clk_i,
  input  wire mul_op_e                                      op_i,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]               mid_i,
  input  wire logic [$clog2(MAX_SAMPLES)-1:0]               span_i,
  input  wire logic [DPS_W-1:0]                             dps_i,
  input  wire logic [RANGE_W-1:0]                           range_i,
  output logic [RANGE_W+DPS_W+$clog2(MAX_SAMPLES)+K_W-1:0]  product_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned A_W   = RANGE_W + DPS_W + IDX_W;
  localparam int unsigned P_W   = A_W + K_W;

  logic [A_W-1:0] op_a;
  logic [K_W-1:0] op_b;
  logic [P_W-1:0] prod_d;
  logic [P_W-1:0] prod_q;

  // Chained ops take the previous product as operand A
  always_comb begin
    unique case (op_i)
      MUL_ANGLE: begin
        op_a = A_W'(mid_i);
        op_b = K_W'(dps_i);
      end
      MUL_SPAN: begin
        op_a = A_W'(span_i);
        op_b = K_W'(dps_i);
      end
      MUL_RANGE_SPAN: begin
        op_a = prod_q[A_W-1:0];
        op_b = K_W'(range_i);
      end
      MUL_SCALE: begin
        op_a = prod_q[A_W-1:0];
        op_b = DEG_TO_RAD_Q24;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (op_i != MUL_IDLE) begin
      prod_q <= prod_d;
    end
  end

  assign product_o = prod_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scan_object_segmenter: directed and random sweeps are
// pushed through the sample port, and each result word is checked against a predictor.
// Depends on sos_pkg and the segmenter RTL only.

module tb_top;
  import sos_pkg::*;

  localparam int unsigned SWEEP_DEPTH  = MAX_SAMPLES_DEF;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned NEAR_MAX     = (1 << NEAR_W) - 1;
  localparam int unsigned RANGE_MAX    = (1 << RANGE_W) - 1;
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no word moving on either side
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned DRAIN_CYCLES = 20;    // outlasts the multiplier sequence of a closing sample
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS  = 15;
  localparam int unsigned LONG_PHASE   = 0;     // phase that carries the overlong sweep

  typedef struct packed {
    logic [NEAR_W-1:0]  near;
    logic [RANGE_W-1:0] rng;
    logic               last;
  } sample_word_t;

  // Field order matches the DUT output ports, so a concatenation fills it.
  typedef struct packed {
    logic               found;
    logic [OBJ_W-1:0]   number;
    logic [ANGLE_W-1:0] angle;
    logic [WIDTH_W-1:0] width;
    logic [RANGE_W-1:0] centre_range;
    logic               done;
  } result_word_t;

  // ---------------------------------------------------------------------------
  // DUT and its signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [NEAR_W-1:0]     near_reading_i = '0;
  logic [RANGE_W-1:0]    range_value_i  = '0;
  logic                  final_sample_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  object_found_o;
  logic [OBJ_W-1:0]      object_number_o;
  logic [ANGLE_W-1:0]    center_angle_o;
  logic [WIDTH_W-1:0]    object_width_o;
  logic [RANGE_W-1:0]    center_range_o;
  logic                  sweep_done_o;

  scan_object_segmenter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .near_reading_i  (near_reading_i),
    .range_value_i   (range_value_i),
    .final_sample_i  (final_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .object_found_o  (object_found_o),
    .object_number_o (object_number_o),
    .center_angle_o  (center_angle_o),
    .object_width_o  (object_width_o),
    .center_range_o  (center_range_o),
    .sweep_done_o    (sweep_done_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  sample_word_t samples_to_send[$];   // filled by the stimulus, drained by the driver
  result_word_t result_words_due[$];  // predicted words, oldest first
  sample_word_t next_sample;
  result_word_t want_word, got_word;
  logic         in_taken = 1'b0;      // sample word accepted at the last rising edge
  bit           steady = 1'b0;        // no idling on either side while set
  int unsigned  send_gap = 0;
  int unsigned  hold_left = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  mismatches = 0;

  // Register settings per random phase: extremes of every register are visited,
  // and the last phase goes back to the reset values.
  int unsigned phase_thr  [NUM_PHASES] = '{2048, 4095, 0, 300, 1500, 1000};
  int unsigned phase_max  [NUM_PHASES] = '{15, 15, 0, 3, 2, 7};
  int unsigned phase_step [NUM_PHASES] = '{1, 180, 255, 0, 3, 2};

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and of the sweep state
  // ---------------------------------------------------------------------------
  logic [NEAR_W-1:0]  thr_q     = NEAR_THR_RST;
  logic [OBJ_W-1:0]   max_obj_q = MAX_OBJ_RST;
  logic [DPS_W-1:0]   step_q    = DPS_RST;

  logic [NEAR_W-1:0]  prev_near      = '0;
  bit                 prev_held      = 1'b0;  // a sample is waiting for its successor
  int unsigned        sample_idx     = 0;
  bit                 in_object      = 1'b0;
  int unsigned        object_start   = 0;
  int unsigned        objects_closed = 0;
  logic [RANGE_W-1:0] range_line_q [SWEEP_DEPTH];

  // Closes the open run at last_idx and builds its result word.
  function automatic result_word_t report_object(int unsigned last_idx);
    result_word_t     r;
    int unsigned      span_idx;
    int unsigned      mid;
    longint unsigned  ang;
    longint unsigned  span_deg;
    longint unsigned  start_rng;
    longint unsigned  w;
    r         = '0;
    span_idx  = (last_idx >= object_start) ? last_idx - object_start : 0;
    mid       = object_start + span_idx / 2;
    ang       = longint'(step_q) * mid;
    if (ang > ANGLE_LIMIT) ang = ANGLE_LIMIT;
    span_deg  = longint'(step_q) * span_idx;
    start_rng = range_line_q[object_start];
    // arc = start range * span * pi/180, Q0.24 constant, rounded half up
    w = (start_rng * span_deg * DEG_TO_RAD_Q24 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
    r.found        = 1'b1;
    r.number       = objects_closed[OBJ_W-1:0];
    r.angle        = ang[ANGLE_W-1:0];
    r.width        = w[WIDTH_W-1:0];
    r.centre_range = range_line_q[mid];
    if (objects_closed < OBJ_COUNT_MAX) objects_closed++;
    in_object = 1'b0;
    return r;
  endfunction

  // One accepted sample in, one predicted result word out. The waiting sample
  // is decided now that its successor has come; the final one is decided at once.
  function automatic result_word_t segment_sample(logic [NEAR_W-1:0] near,
                                                  logic [RANGE_W-1:0] rng, logic last);
    result_word_t r;
    int unsigned  idx;
    int unsigned  prev_idx;
    bit           prev_hit;
    bit           cur_hit;
    r   = '0;
    // overlong sweeps keep overwriting the top entry
    idx = (sample_idx >= SWEEP_DEPTH) ? SWEEP_DEPTH - 1 : sample_idx;
    range_line_q[idx] = rng;
    if (prev_held) begin
      prev_idx = (idx > 0) ? idx - 1 : 0;
      prev_hit = (prev_near >= thr_q);
      cur_hit  = (near >= thr_q);
      if (!in_object && prev_hit && cur_hit && objects_closed < max_obj_q) begin
        in_object    = 1'b1;
        object_start = prev_idx;
      end else if (in_object && !prev_hit && !cur_hit) begin
        r = report_object(prev_idx);
      end
    end
    if (last && in_object) r = report_object(idx);
    if (last) begin
      r.done         = 1'b1;
      prev_near      = '0;
      prev_held      = 1'b0;
      sample_idx     = 0;
      in_object      = 1'b0;
      object_start   = 0;
      objects_closed = 0;
    end else begin
      prev_near  = near;
      prev_held  = 1'b1;
      sample_idx = (idx < SWEEP_DEPTH - 1) ? idx + 1 : SWEEP_DEPTH - 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void flag_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, exp_val, act_val);
  endfunction

  function automatic void check_word(result_word_t exp_w, result_word_t act_w);
    if (act_w.found !== exp_w.found) flag_field("object_found", exp_w.found, act_w.found);
    if (act_w.number !== exp_w.number) flag_field("object_number", exp_w.number, act_w.number);
    if (act_w.angle !== exp_w.angle) flag_field("center_angle", exp_w.angle, act_w.angle);
    if (act_w.width !== exp_w.width) flag_field("object_width", exp_w.width, act_w.width);
    if (act_w.centre_range !== exp_w.centre_range)
      flag_field("center_range", exp_w.centre_range, act_w.centre_range);
    if (act_w.done !== exp_w.done) flag_field("sweep_done", exp_w.done, act_w.done);
  endfunction

  // Rising-edge monitor: predicts on every accepted sample word and checks every
  // accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        result_words_due.push_back(segment_sample(near_reading_i, range_value_i,
                                                  final_sample_i));
      if (out_valid_o && !out_stall_i) begin
        got_word = {object_found_o, object_number_o, center_angle_o, object_width_o,
                    center_range_o, sweep_done_o};
        if (result_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: result word with none due: %p", $realtime, got_word);
        end else begin
          want_word = result_words_due.pop_front();
          check_word(want_word, got_word);
        end
      end
    end
  end

  // Watchdog: a run that stops moving words is a failure.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both changing on the falling edge
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A word is held until taken; a gap only opens once the previous word is gone.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (samples_to_send.size() != 0) begin
        next_sample = samples_to_send.pop_front();
        in_valid_i     <= 1'b1;
        near_reading_i <= next_sample.near;
        range_value_i  <= next_sample.rng;
        final_sample_i <= next_sample.last;
        send_gap       <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!steady && $urandom_range(0, 4) == 0) hold_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Register write; the predictor copy follows it. Only called while idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NEAR_THRESHOLD: thr_q     = val[NEAR_W-1:0];
      CFG_MAX_OBJECTS:    max_obj_q = val[OBJ_W-1:0];
      CFG_DEG_PER_STEP:   step_q    = val[DPS_W-1:0];
      default: ;
    endcase
  endtask

  // Sender has nothing left, nothing is due, and the block has had time to settle.
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || in_valid_i || result_words_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_sample(int unsigned near, int unsigned rng, bit last);
    sample_word_t s;
    s.near = near[NEAR_W-1:0];
    s.rng  = rng[RANGE_W-1:0];
    s.last = last;
    samples_to_send.push_back(s);
  endtask

  function automatic int unsigned pick_near(bit hit);
    if (hit) return $urandom_range(int'(thr_q), NEAR_MAX);
    if (thr_q == 0) return 0;
    return $urandom_range(0, int'(thr_q) - 1);
  endfunction

  function automatic int unsigned pick_range();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return RANGE_MAX;
      default: return $urandom_range(0, RANGE_MAX);
    endcase
  endfunction

  // One sweep of len samples. Well-formed sweeps alternate near and far
  // stretches so runs open and close; noisy ones take any reading.
  task automatic queue_sweep(int unsigned len, bit noisy, int unsigned seg_max);
    bit          hit;
    int unsigned seg_left;
    hit      = $urandom_range(0, 1);
    seg_left = $urandom_range(1, seg_max);
    for (int unsigned i = 0; i < len; i++) begin
      if (seg_left == 0) begin
        hit      = !hit;
        seg_left = $urandom_range(1, seg_max);
      end
      seg_left--;
      add_sample(noisy ? $urandom_range(0, NEAR_MAX) : pick_near(hit), pick_range(),
                 i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned len;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, reset register values (threshold 1000, 7 objects, 2 deg).
    // Single-sample sweep: nothing can open.
    add_sample(NEAR_MAX, RANGE_MAX, 1'b1);
    // Run over the first samples, closed by two far ones (999 just below the
    // threshold); a second run opens at exactly the threshold and is still
    // open at the sweep end.
    add_sample(NEAR_MAX, 0, 1'b0);
    add_sample(NEAR_MAX, RANGE_MAX, 1'b0);
    add_sample(1000, 100, 1'b0);
    add_sample(999, 200, 1'b0);
    add_sample(0, 300, 1'b0);
    add_sample(1000, 5000, 1'b0);
    add_sample(1000, 6000, 1'b0);
    add_sample(0, 7000, 1'b0);
    add_sample(NEAR_MAX, 8000, 1'b1);
    // Object limit lowered mid-sweep: one run closes, then the limit drops
    // to one and a second near stretch must not open.
    add_sample(2000, 1234, 1'b0);
    add_sample(2000, 4321, 1'b0);
    add_sample(0, 1, 1'b0);
    add_sample(0, 2, 1'b0);
    wait_idle();
    write_reg(CFG_SPARE_IDX, '1);
    write_reg(CFG_MAX_OBJECTS, CFG_DATA_W'(1));
    add_sample(3000, 11, 1'b0);
    add_sample(3000, 12, 1'b0);
    add_sample(0, 13, 1'b0);
    add_sample(0, 14, 1'b1);
    // Run opened on the sample just before the final one, closed by it.
    add_sample(NEAR_MAX, 9999, 1'b0);
    add_sample(NEAR_MAX, 16000, 1'b1);
    wait_idle();

    // Random part, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_NEAR_THRESHOLD, CFG_DATA_W'(phase_thr[p]));
      write_reg(CFG_MAX_OBJECTS, CFG_DATA_W'(phase_max[p]));
      write_reg(CFG_DEG_PER_STEP, CFG_DATA_W'(phase_step[p]));
      steady = (p == NUM_PHASES - 1);
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = $urandom_range(25, 48);
          default: len = $urandom_range(2, 16);
        endcase
        queue_sweep(len, $urandom_range(0, 4) == 0, 6);
        sent += len;
      end
      // Overlong sweep: the sample index saturates at the top of the range line.
      if (p == LONG_PHASE) queue_sweep(SWEEP_DEPTH + $urandom_range(2, 20), 1'b0, 40);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
